/* sv/chtu_pkg.sv */
// package for the correction history table unit
// sizes, codes and the queue entry type shared by all other files but chtu_ram
// depends on nothing
`default_nettype none

package chtu_pkg;

  localparam int TABLE_COUNT  = 5;
  localparam int TABLE_PAWN   = 0;
  localparam int TABLE_WHITE  = 1;
  localparam int TABLE_BLACK  = 2;
  localparam int TABLE_MAJOR  = 3;
  localparam int TABLE_MINOR  = 4;

  // entries per row, a power of two so a key reduces by a mask
  localparam int IDX_W        = 14;
  localparam int ENTRY_COUNT  = 1 << IDX_W;
  localparam int ADDR_W       = IDX_W + 1;

  localparam int GRAIN_SHIFT  = 8;
  localparam int GRAIN        = 1 << GRAIN_SHIFT;
  localparam int WS_SHIFT     = 8;
  localparam int WEIGHT_SCALE = 1 << WS_SHIFT;
  localparam int ENTRY_LIMIT  = 8192;
  localparam int MAX_WEIGHT   = 16;

  localparam int KEY_W        = 64;
  localparam int DEPTH_W      = 8;
  localparam int DIFF_W       = 16;
  localparam int CORR_W       = 9;
  localparam int ENTRY_W      = $clog2(ENTRY_LIMIT + 1) + 1;
  localparam int WEIGHT_W     = $clog2(MAX_WEIGHT + 1);
  localparam int PROD_W       = ENTRY_W + WS_SHIFT + 1;
  localparam int TGT_W        = DIFF_W + WEIGHT_W + 1;
  localparam int MIX_W        = ((PROD_W > TGT_W + GRAIN_SHIFT) ? PROD_W
                                 : TGT_W + GRAIN_SHIFT) + 1;
  localparam int SUM_W        = ENTRY_W + $clog2(TABLE_COUNT);
  localparam int CORR_MAX     = (1 << (CORR_W - 1)) - 1;
  localparam int CORR_MIN     = -(1 << (CORR_W - 1));

  localparam int QDEPTH       = 2;
  localparam int QPTR_W       = $clog2(QDEPTH);

  localparam logic KIND_UPDATE = 1'b0;
  localparam logic KIND_QUERY  = 1'b1;

  typedef struct packed {
    logic                                kind;
    logic [TABLE_COUNT-1:0][ADDR_W-1:0]  addr;
    logic [WEIGHT_W-1:0]                 weight;
    logic signed [DIFF_W-1:0]            diff;
  } op_t;

endpackage

`default_nettype wire

/* sv/chtu_if.sv */
// valid/ready channel interfaces for items and results
// depends on chtu_pkg
`default_nettype none

interface chtu_in_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 kind;
  logic                                 side;
  logic [chtu_pkg::KEY_W-1:0]           pawn_key;
  logic [chtu_pkg::KEY_W-1:0]           white_nonpawn_key;
  logic [chtu_pkg::KEY_W-1:0]           black_nonpawn_key;
  logic [chtu_pkg::KEY_W-1:0]           major_key;
  logic [chtu_pkg::KEY_W-1:0]           minor_key;
  logic [chtu_pkg::DEPTH_W-1:0]         search_depth;
  logic signed [chtu_pkg::DIFF_W-1:0]   eval_diff;

  modport source (output valid, kind, side, pawn_key, white_nonpawn_key, black_nonpawn_key,
                  major_key, minor_key, search_depth, eval_diff, input ready);
  modport sink (input valid, kind, side, pawn_key, white_nonpawn_key, black_nonpawn_key,
                major_key, minor_key, search_depth, eval_diff, output ready);
endinterface

interface chtu_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [chtu_pkg::CORR_W-1:0]   correction;

  modport source (output valid, correction, input ready);
  modport sink (input valid, correction, output ready);
endinterface

`default_nettype wire

/* sv/chtu_ram.sv */
// generic single write port, registered read port ram
// no dependencies
`default_nettype none

module chtu_ram #(
  parameter int ADDR_W = 15,
  parameter int DATA_W = 15
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [DATA_W-1:0] wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [1 << ADDR_W];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* sv/chtu_front.sv */
// front end: accepts items, derives table addresses and blend weight
// depends on chtu_pkg and chtu_if
`default_nettype none

module chtu_front (
  chtu_in_if.sink          item,
  input  wire logic        q_full,
  input  wire logic        clearing,
  output logic             push,
  output chtu_pkg::op_t    push_data
);

  logic [chtu_pkg::KEY_W-1:0] keys [chtu_pkg::TABLE_COUNT];

  assign keys[chtu_pkg::TABLE_PAWN]  = item.pawn_key;
  assign keys[chtu_pkg::TABLE_WHITE] = item.white_nonpawn_key;
  assign keys[chtu_pkg::TABLE_BLACK] = item.black_nonpawn_key;
  assign keys[chtu_pkg::TABLE_MAJOR] = item.major_key;
  assign keys[chtu_pkg::TABLE_MINOR] = item.minor_key;

  assign item.ready = !q_full && !clearing;
  assign push       = item.valid && item.ready;

  always_comb begin
    push_data.kind = item.kind;
    // row of the side sits on top, key modulo the row size below
    for (int i = 0; i < chtu_pkg::TABLE_COUNT; i++) begin
      push_data.addr[i] = {item.side, keys[i][chtu_pkg::IDX_W-1:0]};
    end
    if (item.search_depth >= chtu_pkg::DEPTH_W'(chtu_pkg::MAX_WEIGHT - 1)) begin
      push_data.weight = chtu_pkg::WEIGHT_W'(chtu_pkg::MAX_WEIGHT);
    end else begin
      push_data.weight = chtu_pkg::WEIGHT_W'(item.search_depth) + chtu_pkg::WEIGHT_W'(1);
    end
    push_data.diff = item.eval_diff;
  end

endmodule

`default_nettype wire

/* sv/chtu_queue.sv */
// short queue between front and back end
// depends on chtu_pkg
`default_nettype none

module chtu_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire chtu_pkg::op_t  push_data,
  output logic                full,
  input  wire logic           pop,
  output chtu_pkg::op_t       pop_data,
  output logic                pop_valid
);

  chtu_pkg::op_t                  slots [chtu_pkg::QDEPTH];
  logic [chtu_pkg::QPTR_W-1:0]    wr_ptr;
  logic [chtu_pkg::QPTR_W-1:0]    rd_ptr;
  logic [chtu_pkg::QPTR_W:0]      count;

  assign full      = count == (chtu_pkg::QPTR_W + 1)'(chtu_pkg::QDEPTH);
  assign pop_valid = count != '0;
  assign pop_data  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == chtu_pkg::QPTR_W'(chtu_pkg::QDEPTH - 1)) ? '0
                  : wr_ptr + chtu_pkg::QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == chtu_pkg::QPTR_W'(chtu_pkg::QDEPTH - 1)) ? '0
                  : rd_ptr + chtu_pkg::QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + (chtu_pkg::QPTR_W + 1)'(1);
      end else if (pop && !push) begin
        count <= count - (chtu_pkg::QPTR_W + 1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

`default_nettype wire

/* sv/chtu_back.sv */
// back end: table memories, clearing pass, blend updates and query sums
// depends on chtu_pkg, chtu_if and chtu_ram
`default_nettype none

module chtu_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire chtu_pkg::op_t  q_data,
  input  wire logic           q_valid,
  output logic                q_pop,
  output logic                clearing,
  chtu_out_if.source          result
);

  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_READ  = 7'b0000100,
    S_MUL   = 7'b0001000,
    S_WRITE = 7'b0010000,
    S_SUM   = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_t;

  state_t                                 state;
  logic [chtu_pkg::ADDR_W-1:0]            clr_addr;
  chtu_pkg::op_t                          cur;
  logic signed [chtu_pkg::ENTRY_W-1:0]    rd    [chtu_pkg::TABLE_COUNT];
  logic signed [chtu_pkg::ENTRY_W-1:0]    nv    [chtu_pkg::TABLE_COUNT];
  logic signed [chtu_pkg::PROD_W-1:0]     p1    [chtu_pkg::TABLE_COUNT];
  logic signed [chtu_pkg::TGT_W-1:0]      p2;
  logic [chtu_pkg::WS_SHIFT-1:0]          rest;
  logic signed [chtu_pkg::SUM_W-1:0]      sum_next;
  logic signed [chtu_pkg::SUM_W-1:0]      sum_r;
  logic signed [chtu_pkg::SUM_W-1:0]      sum_bias;
  logic signed [chtu_pkg::SUM_W-1:0]      quot;
  logic signed [chtu_pkg::CORR_W-1:0]     corr_next;
  logic                                   out_valid;
  logic signed [chtu_pkg::CORR_W-1:0]     out_data;
  logic                                   out_load;
  logic                                   we;

  assign clearing          = state == S_CLEAR;
  assign q_pop             = (state == S_IDLE) && q_valid;
  assign we                = clearing || (state == S_WRITE);
  // output register free or being drained this cycle
  assign out_load          = (state == S_OUT) && (!out_valid || result.ready);
  assign result.valid      = out_valid;
  assign result.correction = out_data;

  for (genvar g = 0; g < chtu_pkg::TABLE_COUNT; g++) begin : g_table
    logic signed [chtu_pkg::MIX_W-1:0] mix;
    logic signed [chtu_pkg::MIX_W-1:0] bias;
    logic signed [chtu_pkg::MIX_W-1:0] qd;

    chtu_ram #(
      .ADDR_W (chtu_pkg::ADDR_W),
      .DATA_W (chtu_pkg::ENTRY_W)
    ) u_ram (
      .clk   (clk),
      .we    (we),
      .waddr (clearing ? clr_addr : cur.addr[g]),
      .wdata (clearing ? '0 : nv[g]),
      .raddr (cur.addr[g]),
      .rdata (rd[g])
    );

    // blend, divide by the weight scale toward zero, clamp
    always_comb begin
      mix  = chtu_pkg::MIX_W'(p1[g]) + (chtu_pkg::MIX_W'(p2) <<< chtu_pkg::GRAIN_SHIFT);
      bias = mix[chtu_pkg::MIX_W-1] ? chtu_pkg::MIX_W'(chtu_pkg::WEIGHT_SCALE - 1) : '0;
      qd   = (mix + bias) >>> chtu_pkg::WS_SHIFT;
      if (qd > chtu_pkg::MIX_W'(chtu_pkg::ENTRY_LIMIT)) begin
        nv[g] = chtu_pkg::ENTRY_W'(chtu_pkg::ENTRY_LIMIT);
      end else if (qd < chtu_pkg::MIX_W'(-chtu_pkg::ENTRY_LIMIT)) begin
        nv[g] = chtu_pkg::ENTRY_W'(-chtu_pkg::ENTRY_LIMIT);
      end else begin
        nv[g] = qd[chtu_pkg::ENTRY_W-1:0];
      end
    end
  end

  always_comb begin
    rest     = chtu_pkg::WS_SHIFT'(chtu_pkg::WEIGHT_SCALE - int'(cur.weight));
    sum_next = '0;
    for (int i = 0; i < chtu_pkg::TABLE_COUNT; i++) begin
      sum_next = sum_next + chtu_pkg::SUM_W'(rd[i]);
    end
    // divide by grain toward zero, then saturate to the result field
    sum_bias = sum_r[chtu_pkg::SUM_W-1] ? chtu_pkg::SUM_W'(chtu_pkg::GRAIN - 1) : '0;
    quot     = (sum_r + sum_bias) >>> chtu_pkg::GRAIN_SHIFT;
    if (quot > chtu_pkg::SUM_W'(chtu_pkg::CORR_MAX)) begin
      corr_next = chtu_pkg::CORR_W'(chtu_pkg::CORR_MAX);
    end else if (quot < chtu_pkg::SUM_W'(chtu_pkg::CORR_MIN)) begin
      corr_next = chtu_pkg::CORR_W'(chtu_pkg::CORR_MIN);
    end else begin
      corr_next = quot[chtu_pkg::CORR_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + chtu_pkg::ADDR_W'(1);
          if (clr_addr == '1) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (q_valid) begin
            state <= S_READ;
          end
        end
        S_READ: begin
          state <= (cur.kind == chtu_pkg::KIND_QUERY) ? S_SUM : S_MUL;
        end
        S_MUL: begin
          state <= S_WRITE;
        end
        S_WRITE: begin
          state <= S_IDLE;
        end
        S_SUM: begin
          state <= S_OUT;
        end
        S_OUT: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_data;
    end
    if (state == S_MUL) begin
      for (int i = 0; i < chtu_pkg::TABLE_COUNT; i++) begin
        p1[i] <= rd[i] * $signed({1'b0, rest});
      end
      p2 <= cur.diff * $signed({1'b0, cur.weight});
    end
    if (state == S_SUM) begin
      sum_r <= sum_next;
    end
    if (out_load) begin
      out_data <= corr_next;
    end
  end

endmodule

`default_nettype wire

/* sv/correction_history_table_unit.sv */
// correction history table unit: an update item passes pop, memory read, multiply and
// write back; a query passes pop, memory read, sum and output, where it waits for the
// output register; a new item is taken only when the last is done, set by the back end's
// read-modify-write sequence on the single read and write port of each table memory;
// a 2-entry queue buffers items; after reset a clearing pass writes zero to all tables,
// no item accepted; depends on chtu_pkg, chtu_if, chtu_front, chtu_queue, chtu_back
`default_nettype none

module correction_history_table_unit (
  input  wire logic   clk,
  input  wire logic   rst,
  chtu_in_if.sink     item,
  chtu_out_if.source  result
);

  logic            push;
  chtu_pkg::op_t   push_data;
  logic            q_full;
  logic            q_pop;
  chtu_pkg::op_t   pop_data;
  logic            pop_valid;
  logic            clearing;

  chtu_front u_front (
    .item      (item),
    .q_full    (q_full),
    .clearing  (clearing),
    .push      (push),
    .push_data (push_data)
  );

  chtu_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (pop_data),
    .pop_valid (pop_valid)
  );

  chtu_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_data   (pop_data),
    .q_valid  (pop_valid),
    .q_pop    (q_pop),
    .clearing (clearing),
    .result   (result)
  );

endmodule

`default_nettype wire
